// File: rtl/bit_run_frame_packer_defines.svh
// Assertion macros of the bit run frame packer RTL, used by brfp_back.
`ifndef BIT_RUN_FRAME_PACKER_DEFINES_SVH
`define BIT_RUN_FRAME_PACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BRFP_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/brfp_pkg.sv
// Shared types, constants and helpers of the bit run frame packer.
package brfp_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int LIM_W           = POS_W + 1;
    localparam int Q_DEPTH         = 2;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int CFG_AW          = 3;
    localparam int CFG_DW          = 32;
    localparam int FB_W            = 7;

    localparam logic [FB_W-1:0]     FRAME_BYTES_RST = 7'd64;
    // Register index as decoded from paddr word bits.
    localparam logic [CFG_AW-3:0]   REG_FRAME_BYTES = 1'b0;

    typedef struct packed {
        logic       bit_value;
        logic [7:0] run_length;
    } t_run;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_res;

    typedef struct packed {
        logic vld;
        t_run run;
    } t_qhead;

    // Clamp the programmed frame length into 1..MAX_FRAME_BYTES.
    function automatic logic [LIM_W-1:0] sat_limit(input logic [FB_W-1:0] fb);
        logic [LIM_W-1:0] lim;
        if (fb == '0) begin
            lim = LIM_W'(1);
        end else if (fb > FB_W'(MAX_FRAME_BYTES)) begin
            lim = LIM_W'(MAX_FRAME_BYTES);
        end else begin
            lim = LIM_W'(fb);
        end
        return lim;
    endfunction

endpackage

// File: rtl/bit_run_frame_packer.sv
// Top level of the bit run frame packer: register port, intake and packer.
//
// Usage:
//   Input words (i_run_vld / o_run_stall) carry a run: a bit value and a
//   length of 0..255 bits. Bits are packed MSB first into the frame store.
//   Empty runs are taken and dropped. When the frame reaches frame_bytes
//   bytes (clamped to 1..64) every byte goes out in store order as an
//   output word (o_res_vld / i_res_stall), the final one with last_byte
//   set; the rest of the run that closed the frame is discarded.
//   Throughput: a run is first taken from the queue, then packed at up to
//   eight bits a cycle while no frame drains. A frame drains at one byte
//   a cycle while the output is not stalled, each byte passing the store
//   read register and then the output register, bounded by the single
//   store read port. A two-entry queue lets runs keep arriving while a
//   frame drains. A stall on the output holds the output word and
//   back-pressures the drain; the queue then fills and o_run_stall rises.
//   Reset empties the queue, zeroes both positions and sets frame_bytes
//   to 64. The store needs no clearing pass: only bytes written in the
//   current frame are ever read.
//   Write frame_bytes over the APB port (byte address 0) only when idle.
module bit_run_frame_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // run input
    input  logic                          i_run_vld,
    input  brfp_pkg::t_run                i_run,
    output logic                          o_run_stall,
    // byte output
    output logic                          o_res_vld,
    output brfp_pkg::t_res                o_res,
    input  logic                          i_res_stall,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brfp_pkg::CFG_AW-1:0]   paddr,
    input  logic [brfp_pkg::CFG_DW-1:0]   pwdata,
    output logic [brfp_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import brfp_pkg::*;

    logic [FB_W-1:0]  r_frame_bytes;
    logic             cfg_hit;
    logic             cfg_wr;
    logic [LIM_W-1:0] limit;
    t_qhead           qhead;
    logic             pop;

    // Decode the word address; everything else reads as zero.
    assign cfg_hit = (paddr[CFG_AW-1:2] == REG_FRAME_BYTES);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? CFG_DW'(r_frame_bytes) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_BYTES_RST;
        end else if (cfg_wr) begin
            r_frame_bytes <= pwdata[FB_W-1:0];
        end
    end

    // Clamp out-of-range lengths so zero acts as one byte.
    assign limit = sat_limit(r_frame_bytes);

    brfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_vld   (i_run_vld),
        .i_run       (i_run),
        .o_run_stall (o_run_stall),
        .o_q         (qhead),
        .i_pop       (pop)
    );

    brfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (limit),
        .i_q         (qhead),
        .o_pop       (pop),
        .o_res_vld   (o_res_vld),
        .o_res       (o_res),
        .i_res_stall (i_res_stall)
    );

endmodule

// File: rtl/brfp_ram.sv
// Generic simple dual-port RAM with registered read.
module brfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/brfp_front.sv
// Run intake: drops empty runs and queues the rest for the packer.
module brfp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_run_vld,
    input  brfp_pkg::t_run i_run,
    output logic          o_run_stall,
    output brfp_pkg::t_qhead o_q,
    input  logic          i_pop
);
    import brfp_pkg::*;

    t_run              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_cnt;
    logic              full;
    logic              push;
    logic              pop;

    assign full        = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_run_stall = full;
    // Empty runs are accepted and dropped here.
    assign push        = i_run_vld && !full && (i_run.run_length != 8'd0);
    assign pop         = i_pop && (r_cnt != '0);

    assign o_q.vld = (r_cnt != '0);
    assign o_q.run = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/brfp_back.sv
// Packer and frame drain: fills bytes from queued runs and streams full frames.
`include "bit_run_frame_packer_defines.svh"
module brfp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [brfp_pkg::LIM_W-1:0]  i_limit,
    input  brfp_pkg::t_qhead            i_q,
    output logic                        o_pop,
    output logic                        o_res_vld,
    output brfp_pkg::t_res              o_res,
    input  logic                        i_res_stall
);
    import brfp_pkg::*;

    typedef enum logic [1:0] {
        ST_PACK  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_left, n_left;
    logic             r_val, n_val;
    logic [2:0]       r_bit_pos, n_bit_pos;
    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [7:0]       r_cur, n_cur;
    logic [POS_W-1:0] r_rd_addr, n_rd_addr;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;
    logic             r_out_vld, n_out_vld;
    t_res             r_out, n_out;

    logic [3:0]       avail;
    logic [3:0]       take;
    logic [3:0]       end_pos;
    logic [7:0]       mask;
    logic [7:0]       byte_val;
    logic             packing;
    logic             byte_done;
    logic             frame_end;
    logic             out_adv;
    logic             rd_issue;
    logic             rd_last;
    logic [7:0]       rd_data;

    // Bits that fit in the current byte this cycle.
    assign avail    = 4'd8 - {1'b0, r_bit_pos};
    assign take     = (r_left < {4'b0, avail}) ? r_left[3:0] : avail;
    assign end_pos  = {1'b0, r_bit_pos} + take;
    assign mask     = (8'hFF >> r_bit_pos) & ~(8'hFF >> end_pos);
    assign byte_val = r_val ? (r_cur | mask) : r_cur;

    assign packing   = (r_state == ST_PACK) && (r_left != 8'd0);
    assign byte_done = packing && end_pos[3];
    assign frame_end = byte_done && (({1'b0, r_byte_pos} + LIM_W'(1)) >= i_limit);
    assign o_pop     = (r_state == ST_PACK) && (r_left == 8'd0) && i_q.vld;

    assign out_adv  = !r_out_vld || !i_res_stall;
    assign rd_issue = (r_state == ST_DRAIN) && (!r_rd_vld || out_adv);
    assign rd_last  = (({1'b0, r_rd_addr} + LIM_W'(1)) == i_limit);

    brfp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (byte_done),
        .i_waddr (r_byte_pos),
        .i_wdata (byte_val),
        .i_re    (rd_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_val      = r_val;
        n_bit_pos  = r_bit_pos;
        n_byte_pos = r_byte_pos;
        n_cur      = r_cur;
        n_rd_addr  = r_rd_addr;
        n_rd_vld   = r_rd_vld;
        n_rd_last  = r_rd_last;
        n_out_vld  = r_out_vld;
        n_out      = r_out;

        case (r_state)
            ST_PACK: begin
                if (o_pop) begin
                    n_left = i_q.run.run_length;
                    n_val  = i_q.run.bit_value;
                end else if (packing) begin
                    n_left = r_left - {4'b0, take};
                    if (byte_done) begin
                        n_cur     = 8'd0;
                        n_bit_pos = 3'd0;
                        if (frame_end) begin
                            n_left     = 8'd0;
                            n_byte_pos = '0;
                            n_rd_addr  = '0;
                            n_state    = ST_DRAIN;
                        end else begin
                            n_byte_pos = r_byte_pos + POS_W'(1);
                        end
                    end else begin
                        n_cur     = byte_val;
                        n_bit_pos = end_pos[2:0];
                    end
                end
            end
            ST_DRAIN: begin
                if (rd_issue) begin
                    n_rd_last = rd_last;
                    if (rd_last) begin
                        n_state = ST_PACK;
                    end else begin
                        n_rd_addr = r_rd_addr + POS_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_PACK;
            end
        endcase

        if (out_adv) begin
            n_out_vld       = r_rd_vld;
            n_out.out_byte  = rd_data;
            n_out.last_byte = r_rd_last;
        end
        if (rd_issue) begin
            n_rd_vld = 1'b1;
        end else if (out_adv) begin
            n_rd_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_out  <= n_out;
        r_rd_addr <= n_rd_addr;
        r_rd_last <= n_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_PACK;
            r_left     <= 8'd0;
            r_bit_pos  <= 3'd0;
            r_byte_pos <= '0;
            r_cur      <= 8'd0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_left     <= n_left;
            r_bit_pos  <= n_bit_pos;
            r_byte_pos <= n_byte_pos;
            r_cur      <= n_cur;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    `BRFP_ASSERT(a_no_pop_in_drain, r_state == ST_DRAIN, !o_pop, "run popped during drain")
    `BRFP_ASSERT_NXT(a_end_to_drain, frame_end, r_state == ST_DRAIN, "frame end missed drain")
    `BRFP_ASSERT(a_rd_in_frame, rd_issue, (r_rd_addr < i_limit[POS_W-1:0]) || i_limit[POS_W], "drain read past frame")
    `BRFP_ASSERT_NXT(a_last_ends_drain, rd_issue && rd_last, r_state == ST_PACK, "drain overran last byte")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the bit run frame packer: directed and random runs.
`timescale 1ns / 1ps

module testbench;
    import brfp_pkg::*;

    // Byte addresses on the register port. The spare address sits one word
    // above frame_bytes and has no register behind it.
    localparam logic [CFG_AW-1:0] ADDR_FRAME_BYTES = {REG_FRAME_BYTES, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_SPARE       = ADDR_FRAME_BYTES + CFG_AW'(4);

    // A run of 255 bits touches up to 33 bytes. Up to three runs (two queued, one
    // in the packer) may still be working after the last byte has come out.
    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 9;
    localparam int RUNS_PER_PHASE = 26;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_run_vld   = 1'b0;
    t_run                  i_run       = '0;
    logic                  o_run_stall;
    logic                  o_res_vld;
    t_res                  o_res;
    logic                  i_res_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_AW-1:0]     paddr       = '0;
    logic [CFG_DW-1:0]     pwdata      = '0;
    logic [CFG_DW-1:0]     prdata;
    logic                  pready;

    bit_run_frame_packer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_vld   (i_run_vld),
        .i_run       (i_run),
        .o_run_stall (o_run_stall),
        .o_res_vld   (o_res_vld),
        .o_res       (o_res),
        .i_res_stall (i_res_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the packer: frame store, fill positions and the
    // programmed frame length, all as the block should hold them.
    logic [7:0]      shadow_store [MAX_FRAME_BYTES];
    int              shadow_byte;
    int              shadow_bit;
    logic [FB_W-1:0] frame_len_reg;

    // Bytes of emitted frames still owed by the block, oldest first.
    t_res            frame_bytes_due [$];
    t_res            due_word;

    int              mismatch_count;
    int              runs_sent;
    int              bytes_checked;
    int              frames_checked;
    int              settings_used;
    int              quiet_cycles;
    bit              sender_tight;
    int              stall_hold;
    int              stall_pick;

    initial begin
        for (int n = 0; n < MAX_FRAME_BYTES; n++) begin
            shadow_store[n] = 8'h00;
        end
        shadow_byte    = 0;
        shadow_bit     = 0;
        frame_len_reg  = FRAME_BYTES_RST;
        mismatch_count = 0;
        runs_sent      = 0;
        bytes_checked  = 0;
        frames_checked = 0;
        settings_used  = 0;
        quiet_cycles   = 0;
        sender_tight   = 1'b0;
        stall_hold     = 0;
    end

    // Append one run to the shadow store and queue the frame it closes, if
    // any. The frame length is clamped into 1..MAX_FRAME_BYTES; once a frame
    // goes out, drop the rest of the run and clear the whole store.
    task automatic pack_run(input t_run run);
        int   limit;
        t_res word;
        if (frame_len_reg == '0) begin
            limit = 1;
        end else if (frame_len_reg > MAX_FRAME_BYTES) begin
            limit = MAX_FRAME_BYTES;
        end else begin
            limit = int'(frame_len_reg);
        end
        for (int n = 0; n < run.run_length; n++) begin
            if (run.bit_value) begin
                shadow_store[shadow_byte] = shadow_store[shadow_byte] | (8'h80 >> shadow_bit);
            end
            shadow_bit++;
            if (shadow_bit == 8) begin
                shadow_bit = 0;
                shadow_byte++;
                // A frame shortened below the fill point closes on this byte.
                if (shadow_byte >= limit) begin
                    for (int k = 0; k < limit; k++) begin
                        word.out_byte  = shadow_store[k];
                        word.last_byte = (k == limit - 1);
                        frame_bytes_due.push_back(word);
                    end
                    for (int k = 0; k < MAX_FRAME_BYTES; k++) begin
                        shadow_store[k] = 8'h00;
                    end
                    shadow_byte = 0;
                    return;
                end
                shadow_byte = shadow_byte % MAX_FRAME_BYTES;
            end
        end
    endtask

    // Mostly back to back, sometimes a few cycles, now and then a long pause.
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (sender_tight || pick < 11) begin
            return 0;
        end else if (pick < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one run word and hold it until taken. Valid stays high after the
    // handshake; the next call either replaces the word or drops valid for a gap.
    task automatic send_run(input logic value, input logic [7:0] length);
        t_run run;
        int   gap;
        run.bit_value  = value;
        run.run_length = length;
        gap = sender_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_run_vld <= 1'b0;
        end
        @(negedge i_clk);
        i_run_vld <= 1'b1;
        i_run     <= run;
        do @(posedge i_clk); while (o_run_stall);
        pack_run(run);
        runs_sent++;
    endtask

    // Drop valid, wait for every owed byte, then let runs that close no
    // frame finish inside the block.
    task automatic wait_idle();
        @(negedge i_clk);
        i_run_vld <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [CFG_AW-1:0] addr, output logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program frame_bytes while idle, mirror it in the shadow and read it
    // back. Only the low seven bits of the written word land in the register.
    task automatic set_frame_bytes(input logic [CFG_DW-1:0] data);
        logic [CFG_DW-1:0] readback;
        wait_idle();
        apb_write(ADDR_FRAME_BYTES, data);
        frame_len_reg = data[FB_W-1:0];
        settings_used++;
        apb_read(ADDR_FRAME_BYTES, readback);
        if (readback !== CFG_DW'(frame_len_reg)) begin
            $error("frame_bytes readback: expected %0d, got %0d", frame_len_reg, readback);
            mismatch_count++;
        end
    endtask

    // Default length of 64 bytes straight out of reset. An empty run of each
    // value changes nothing; the closing run crosses the frame end by nine
    // bits, which must be dropped.
    task automatic test_default_frame();
        send_run(1'b1, 8'd1);
        send_run(1'b1, 8'd0);
        send_run(1'b0, 8'd255);
        send_run(1'b1, 8'd255);
        send_run(1'b0, 8'd0);
        send_run(1'b1, 8'd10);
    endtask

    // A length of zero acts as one byte; a run longer than the frame emits
    // a single frame and loses its tail.
    task automatic test_short_frames();
        set_frame_bytes(32'd0);
        send_run(1'b1, 8'd3);
        send_run(1'b0, 8'd5);
        send_run(1'b1, 8'd20);
        set_frame_bytes(32'd1);
        send_run(1'b0, 8'd1);
        send_run(1'b1, 8'd7);
    endtask

    // Lengths above the maximum act as 64 bytes. All-ones data also checks
    // that the upper word bits are ignored. A write to the spare address is
    // also driven, but frame_bytes is set again before it is read back.
    task automatic test_long_frames();
        set_frame_bytes(32'hFFFF_FFFF);
        send_run(1'b1, 8'd255);
        send_run(1'b0, 8'd255);
        send_run(1'b1, 8'd2);
        wait_idle();
        apb_write(ADDR_SPARE, 32'h0000_0003);
        set_frame_bytes(32'hA5A5_A5C1);
        send_run(1'b0, 8'd200);
        send_run(1'b1, 8'd255);
        send_run(1'b1, 8'd60);
    endtask

    // Fill five of eight bytes, cut the length to two, then complete the
    // sixth byte: bytes 0 and 1 go out and filling restarts at byte 0,
    // which the following frame proves.
    task automatic test_shortened_mid_fill();
        set_frame_bytes(32'd8);
        send_run(1'b1, 8'd12);
        send_run(1'b0, 8'd9);
        send_run(1'b1, 8'd19);
        set_frame_bytes(32'd2);
        send_run(1'b1, 8'd3);
        send_run(1'b0, 8'd5);
        send_run(1'b0, 8'd8);
        send_run(1'b1, 8'd8);
    endtask

    // Random runs under a range of lengths, extremes included. Most runs are
    // short so frames close often; some phases send with no gaps at all.
    task automatic test_random_runs();
        logic [CFG_DW-1:0] setting;
        int                pick;
        logic [7:0]        length;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    setting = 32'd1;
                end
                1: begin
                    setting = 32'd64;
                end
                2: begin
                    setting = 32'd0;
                end
                3: begin
                    setting = 32'd127;
                end
                4: begin
                    setting = 32'd2;
                end
                5: begin
                    setting = 32'd65;
                end
                default: begin
                    setting = {25'($urandom()), 7'($urandom_range(0, 20))};
                end
            endcase
            set_frame_bytes(setting);
            sender_tight = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < RUNS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    length = 8'd0;
                end else if (pick < 4) begin
                    length = 8'($urandom_range(1, 8));
                end else if (pick < 8) begin
                    length = 8'($urandom_range(9, 64));
                end else begin
                    length = 8'($urandom_range(65, 255));
                end
                send_run(1'($urandom_range(0, 1)), length);
            end
            sender_tight = 1'b0;
        end
    endtask

    // Receiver: long stretches with no stall, short stalls, rare long ones.
    // Change only at the falling edge.
    always @(negedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            stall_pick = $urandom_range(0, 9);
            if (stall_pick < 5) begin
                i_res_stall <= 1'b0;
                stall_hold  <= $urandom_range(1, 30);
            end else if (stall_pick < 9) begin
                i_res_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 2);
            end else begin
                i_res_stall <= 1'b1;
                stall_hold  <= $urandom_range(20, 60);
            end
        end
    end

    // Compare every accepted output word with the oldest owed byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_vld && !i_res_stall) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected output word: out_byte %02h, last_byte %0b",
                       o_res.out_byte, o_res.last_byte);
                mismatch_count++;
            end else begin
                due_word = frame_bytes_due.pop_front();
                if (o_res.out_byte !== due_word.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           due_word.out_byte, o_res.out_byte);
                    mismatch_count++;
                end
                if (o_res.last_byte !== due_word.last_byte) begin
                    $error("last_byte: expected %0b, got %0b",
                           due_word.last_byte, o_res.last_byte);
                    mismatch_count++;
                end
                bytes_checked++;
                if (due_word.last_byte) begin
                    frames_checked++;
                end
            end
        end
    end

    // Abort when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if ((i_run_vld && !o_run_stall) || (o_res_vld && !i_res_stall)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_frame();
        test_short_frames();
        test_long_frames();
        test_shortened_mid_fill();
        test_random_runs();
        wait_idle();

        $display("Covered %0d runs over %0d frame length settings, extremes and clamping included.",
                 runs_sent, settings_used + 1);
        $display("Checked %0d output bytes in %0d frames under random gaps and stalls.",
                 bytes_checked, frames_checked);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
